// ===== rtl/aae_pkg.sv =====
// ----------------------------------------------------------------------------
// aae_pkg: shared definitions for the adaptive axis estimator
// Widths, reset values, register indexes, request and response structs of the
// shared arithmetic units, and the saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package aae_pkg;

  localparam int CoordWidthDef = 32;
  localparam int ParWidth      = 48;
  localparam int WideWidth     = 128;
  localparam int NumPar        = 6;
  localparam int DivSteps      = 81;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegStepGain  = 3'd0;
  localparam logic [2:0] RegThreshold = 3'd1;
  localparam logic [2:0] RegAxisX     = 3'd2;
  localparam logic [2:0] RegAxisY     = 3'd3;
  localparam logic [2:0] RegAxisZ     = 3'd4;
  localparam logic [2:0] RegHitsNeed  = 3'd5;
  localparam logic [2:0] RegMaxIter   = 3'd6;

  localparam logic [47:0] StepGainRst  = 48'd2814749767;
  localparam logic [47:0] ThresholdRst = 48'd429497;
  localparam logic [31:0] AxisXRst     = 32'd0;
  localparam logic [31:0] AxisYRst     = 32'd0;
  localparam logic [31:0] AxisZRst     = 32'd1073741824;
  localparam logic [15:0] HitsNeedRst  = 16'd100;
  localparam logic [19:0] MaxIterRst   = 20'd20000;

  localparam logic signed [47:0] ParOne = 48'sh0001_0000_0000;
  localparam logic signed [47:0] Max48  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Min48  = 48'sh8000_0000_0000;
  localparam logic [47:0]        Mask48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                done;
    logic signed [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [47:0] mag;
    logic [48:0] den;
    logic        neg;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quot;
  } div_rsp_t;

  // Coordinate indexes of the six regressor terms: xx, yy, zz, xy, yz, xz.
  function automatic logic [1:0] pair_i(input logic [2:0] idx);
    logic [1:0] r;
    case (idx)
      3'd1, 3'd4: r = 2'd1;
      3'd2:       r = 2'd2;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_j(input logic [2:0] idx);
    logic [1:0] r;
    case (idx)
      3'd1, 3'd3: r = 2'd1;
      3'd2, 3'd4, 3'd5: r = 2'd2;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [127:0] x);
    logic signed [47:0] r;
    if (x[127:47] == {81{1'b0}} || x[127:47] == {81{1'b1}}) r = x[47:0];
    else if (x[127]) r = Min48;
    else r = Max48;
    return r;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [127:0] x);
    logic signed [63:0] r;
    if (x[127:63] == {65{1'b0}} || x[127:63] == {65{1'b1}}) r = x[63:0];
    else if (x[127]) r = {1'b1, {63{1'b0}}};
    else r = {1'b0, {63{1'b1}}};
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aae_in_if.sv =====
// ----------------------------------------------------------------------------
// aae_in_if: point pair channel
// Valid/ready channel that carries two 3D points and the restart flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface aae_in_if #(
  parameter int COORD_WIDTH = aae_pkg::CoordWidthDef
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] first_z;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  logic signed [COORD_WIDTH-1:0] second_z;
  logic                          restart;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  restart, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                restart, output ready);
endinterface

`default_nettype wire

// ===== rtl/aae_out_if.sv =====
// ----------------------------------------------------------------------------
// aae_out_if: estimate channel
// Valid/ready channel that carries the estimate, its normalised diagonal,
// the squared error and the status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface aae_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] est_xx;
  logic signed [47:0] est_yy;
  logic signed [47:0] est_zz;
  logic signed [47:0] est_xy;
  logic signed [47:0] est_yz;
  logic signed [47:0] est_xz;
  logic signed [47:0] norm_xx;
  logic signed [47:0] norm_yy;
  logic signed [47:0] norm_zz;
  logic [47:0]        error_sq;
  logic               converged;
  logic               done_res;

  modport source (output valid, est_xx, est_yy, est_zz, est_xy, est_yz, est_xz, norm_xx,
                  norm_yy, norm_zz, error_sq, converged, done_res, input ready);
  modport sink (input valid, est_xx, est_yy, est_zz, est_xy, est_yz, est_xz, norm_xx,
                norm_yy, norm_zz, error_sq, converged, done_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/aae_mul.sv =====
// ----------------------------------------------------------------------------
// aae_mul: shared multiplier
// Signed 64 x 64 multiply built from one 32 x 32 unsigned multiplier over
// four partial products, then a sign fix.
// ----------------------------------------------------------------------------
`default_nettype none

module aae_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire aae_pkg::mul_req_t req_i,
  output aae_pkg::mul_rsp_t      rsp_o
);

  logic [63:0]  ma_q, mb_q;
  logic         neg_q;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [127:0] acc_q;
  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  assign opa = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign opb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp  = opa * opb;

  always_comb begin
    case (cnt_q)
      3'd0:       pp_sh = {64'd0, pp};
      3'd1, 3'd2: pp_sh = {32'd0, pp, 32'd0};
      3'd3:       pp_sh = {pp, 64'd0};
      default:    pp_sh = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q[2]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ma_q  <= req_i.a[63] ? (~req_i.a + 64'd1) : req_i.a;
      mb_q  <= req_i.b[63] ? (~req_i.b + 64'd1) : req_i.b;
      neg_q <= req_i.a[63] ^ req_i.b[63];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q[2]) acc_q <= neg_q ? (~acc_q + 128'd1) : acc_q;
      else acc_q <= acc_q + pp_sh;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

`default_nettype wire

// ===== rtl/aae_div.sv =====
// ----------------------------------------------------------------------------
// aae_div: capped restoring divider
// Computes (mag << 33) / den one quotient bit per cycle, limiting the
// quotient to the largest magnitude that the signed result can hold.
// ----------------------------------------------------------------------------
`default_nettype none

module aae_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire aae_pkg::div_req_t req_i,
  output aae_pkg::div_rsp_t      rsp_o
);

  localparam int CntW = $clog2(aae_pkg::DivSteps + 1);

  logic [80:0]     num_q;
  logic [49:0]     rem_q;
  logic [48:0]     quo_q;
  logic [48:0]     den_q;
  logic [47:0]     cap_q;
  logic            big_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [49:0]     rem_sh, rem_n;
  logic [48:0]     quo_n;
  logic            ge;

  assign rem_sh = {rem_q[48:0], num_q[80]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_n  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  assign quo_n  = {quo_q[47:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(aae_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= {req_i.mag, 33'd0};
      den_q <= req_i.den;
      cap_q <= req_i.neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      rem_q <= '0;
      quo_q <= '0;
      big_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[79:0], 1'b0};
      rem_q <= rem_n;
      if (!big_q) begin
        quo_q <= quo_n;
        if (quo_n > {1'b0, cap_q}) big_q <= 1'b1;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = big_q ? cap_q : quo_q[47:0];

endmodule

`default_nettype wire

// ===== rtl/adaptive_axis_estimator.sv =====
// ----------------------------------------------------------------------------
// adaptive_axis_estimator: projected-gradient quadric parameter estimator
// Top level: configuration registers, sequencer, estimator state and the
// output register.
// ----------------------------------------------------------------------------
// Usage. Point pairs arrive on in_i (valid/ready); a transfer carries two
// signed Q.16 points and a restart flag that clears the estimate, the hit and
// iteration counters and the stop flag before the pair is used. Each pair
// yields exactly one transfer on out_o with the six Q16.32 parameters, the
// normalised diagonal, the squared diagonal error and the converged and
// done flags. Once stopped, pairs without restart leave the state untouched
// and only report it.
// Timing. One pair is worked at a time; in_i.ready is high only while the
// sequencer is idle. All products go through one shared multiplier built on a
// single 32 x 32 unit and the three normalisations through one bit-serial
// divider. A pair that only reports skips the update steps, and a zero
// diagonal sum skips the divisions.
// Back-pressure. Results sit in an output register; a new pair is accepted
// while a result waits, and the sequencer holds its finished result until the
// register is free. Reset clears the estimate to 1,0,1,0,0,0, the counters and
// the stop flag, and restores the register defaults. Configuration is written
// over the APB-style port at byte address 8 * index and read back there.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_axis_estimator #(
  parameter int COORD_WIDTH = aae_pkg::CoordWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  aae_in_if.sink           in_i,
  aae_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  // Sequencer codes.
  localparam logic [3:0] S_IDLE = 4'd0;   // waiting for a pair
  localparam logic [3:0] S_PHA  = 4'd1;   // first point product
  localparam logic [3:0] S_PHB  = 4'd2;   // second point product, regressor term
  localparam logic [3:0] S_ZH   = 4'd3;   // prediction dot product
  localparam logic [3:0] S_EST  = 4'd4;   // prediction error
  localparam logic [3:0] S_GRD  = 4'd5;   // gradient term
  localparam logic [3:0] S_DLT  = 4'd6;   // scaled step and parameter write
  localparam logic [3:0] S_SUM  = 4'd7;   // diagonal sum
  localparam logic [3:0] S_DIV  = 4'd8;   // normalisation
  localparam logic [3:0] S_TGT  = 4'd9;   // squares of the reference axis
  localparam logic [3:0] S_TGS  = 4'd10;  // target diagonal
  localparam logic [3:0] S_ERR  = 4'd11;  // squared error accumulation
  localparam logic [3:0] S_FIN  = 4'd12;  // counters and stop decision
  localparam logic [3:0] S_OUT  = 4'd13;  // hand over to the output register

  localparam int ExtW = 64 - COORD_WIDTH;

  // Configuration registers.
  logic [47:0] step_gain_q, threshold_q;
  logic [31:0] axis_q [3];
  logic [15:0] hits_need_q;
  logic [19:0] max_iter_q;

  // Estimator state.
  logic signed [47:0] par_q [aae_pkg::NumPar];
  logic [15:0]        hit_q;
  logic [19:0]        iter_q;
  logic               stopped_q;

  // Working registers of one pair.
  logic [3:0]                    state_q;
  logic [2:0]                    idx_q;
  logic                          issued_q;
  logic                          upd_q;
  logic signed [COORD_WIDTH-1:0] crd_a_q [3];
  logic signed [COORD_WIDTH-1:0] crd_b_q [3];
  logic signed [127:0]           m1_q;
  logic signed [47:0]            phi_q [aae_pkg::NumPar];
  logic signed [127:0]           acc_q;
  logic signed [63:0]            e_q, g_q;
  logic signed [49:0]            sum_q;
  logic signed [47:0]            nrm_q [3];
  logic [62:0]                   sq_q [3];
  logic [35:0]                   tgt_q [3];
  logic [47:0]                   esq_q;
  logic                          conv_q;

  // Output register.
  logic               out_valid_q;
  logic signed [47:0] o_est_q [aae_pkg::NumPar];
  logic signed [47:0] o_nrm_q [3];
  logic [47:0]        o_esq_q;
  logic               o_conv_q, o_done_q;

  aae_pkg::mul_req_t mul_req;
  aae_pkg::mul_rsp_t mul_rsp;
  aae_pkg::div_req_t div_req;
  aae_pkg::div_rsp_t div_rsp;

  aae_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));
  aae_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  logic in_acc, out_free, cfg_wr;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;

  function automatic logic signed [63:0] sx(input logic signed [COORD_WIDTH-1:0] c);
    return {{ExtW{c[COORD_WIDTH-1]}}, c};
  endfunction

  // --------------------------------------------------------------------------
  // Operand selection for the shared units.
  // --------------------------------------------------------------------------
  logic [1:0]         pi, pj;
  logic [1:0]         i3;
  logic signed [47:0] par_sel, phi_sel;
  logic signed [63:0] err_op;
  logic               mul_state;

  assign pi      = aae_pkg::pair_i(idx_q);
  assign pj      = aae_pkg::pair_j(idx_q);
  assign i3      = idx_q[1:0];
  assign par_sel = par_q[idx_q];
  assign phi_sel = phi_q[idx_q];
  assign err_op  = {{16{nrm_q[i3][47]}}, nrm_q[i3]} - {28'd0, tgt_q[i3]};

  always_comb begin
    mul_state = 1'b1;
    mul_req.a = '0;
    mul_req.b = '0;
    unique case (state_q)
      S_PHA: begin
        mul_req.a = sx(crd_a_q[pi]);
        mul_req.b = sx(crd_a_q[pj]);
      end
      S_PHB: begin
        mul_req.a = sx(crd_b_q[pi]);
        mul_req.b = sx(crd_b_q[pj]);
      end
      S_ZH: begin
        mul_req.a = {{16{par_sel[47]}}, par_sel};
        mul_req.b = {{16{phi_sel[47]}}, phi_sel};
      end
      S_GRD: begin
        mul_req.a = {{16{phi_sel[47]}}, phi_sel};
        mul_req.b = e_q;
      end
      S_DLT: begin
        mul_req.a = g_q;
        mul_req.b = {16'd0, step_gain_q};
      end
      S_TGT: begin
        mul_req.a = {{32{axis_q[i3][31]}}, axis_q[i3]};
        mul_req.b = {{32{axis_q[i3][31]}}, axis_q[i3]};
      end
      S_ERR: begin
        mul_req.a = err_op;
        mul_req.b = err_op;
      end
      default: mul_state = 1'b0;
    endcase
  end

  assign mul_req.start = mul_state && !issued_q;

  logic signed [49:0] sum_abs;
  logic               div_neg;
  assign sum_abs       = sum_q[49] ? -sum_q : sum_q;
  assign div_neg       = (par_sel != '0) && (par_sel[47] != sum_q[49]);
  assign div_req.start = (state_q == S_DIV) && !issued_q && (sum_q != '0);
  assign div_req.mag   = par_sel[47] ? 48'(-par_sel) : 48'(par_sel);
  assign div_req.den   = sum_abs[48:0];
  assign div_req.neg   = div_neg;

  // --------------------------------------------------------------------------
  // Arithmetic of the individual steps.
  // --------------------------------------------------------------------------
  logic signed [127:0] phi_diff, zh_neg, par_sum;
  logic signed [63:0]  dlt, dlt_p;
  logic signed [127:0] esq_sh;
  logic [47:0]         esq_n;
  logic [15:0]         hit_n;
  logic [19:0]         iter_n;
  logic                stop_n;

  assign phi_diff = m1_q - mul_rsp.prod;
  assign zh_neg   = -acc_q;
  assign dlt      = aae_pkg::sat64(mul_rsp.prod >>> 48);
  // A negative diagonal term is not driven further negative.
  assign dlt_p    = (idx_q < 3'd3 && par_sel[47] && dlt[63]) ? 64'sd0 : dlt;
  assign par_sum  = {{80{par_sel[47]}}, par_sel} + {{64{dlt_p[63]}}, dlt_p};
  assign esq_sh   = acc_q >>> 32;
  assign esq_n    = (esq_sh[127:48] != '0) ? aae_pkg::Mask48 : esq_sh[47:0];

  always_comb begin
    hit_n  = hit_q;
    iter_n = iter_q;
    stop_n = stopped_q;
    if (upd_q) begin
      if (esq_n < threshold_q && hit_q != 16'hFFFF) hit_n = hit_q + 16'd1;
      iter_n = iter_q + 20'd1;
      stop_n = (hit_n >= hits_need_q) || (iter_n >= max_iter_q);
    end
  end

  // --------------------------------------------------------------------------
  // Configuration port.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_gain_q <= aae_pkg::StepGainRst;
      threshold_q <= aae_pkg::ThresholdRst;
      axis_q[0]   <= aae_pkg::AxisXRst;
      axis_q[1]   <= aae_pkg::AxisYRst;
      axis_q[2]   <= aae_pkg::AxisZRst;
      hits_need_q <= aae_pkg::HitsNeedRst;
      max_iter_q  <= aae_pkg::MaxIterRst;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        aae_pkg::RegStepGain:  step_gain_q <= pwdata[47:0];
        aae_pkg::RegThreshold: threshold_q <= pwdata[47:0];
        aae_pkg::RegAxisX:     axis_q[0]   <= pwdata[31:0];
        aae_pkg::RegAxisY:     axis_q[1]   <= pwdata[31:0];
        aae_pkg::RegAxisZ:     axis_q[2]   <= pwdata[31:0];
        aae_pkg::RegHitsNeed:  hits_need_q <= pwdata[15:0];
        aae_pkg::RegMaxIter:   max_iter_q  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      aae_pkg::RegStepGain:  prdata = {16'd0, step_gain_q};
      aae_pkg::RegThreshold: prdata = {16'd0, threshold_q};
      aae_pkg::RegAxisX:     prdata = {32'd0, axis_q[0]};
      aae_pkg::RegAxisY:     prdata = {32'd0, axis_q[1]};
      aae_pkg::RegAxisZ:     prdata = {32'd0, axis_q[2]};
      aae_pkg::RegHitsNeed:  prdata = {48'd0, hits_need_q};
      aae_pkg::RegMaxIter:   prdata = {44'd0, max_iter_q};
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and estimator state.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      issued_q  <= 1'b0;
      upd_q     <= 1'b0;
      hit_q     <= '0;
      iter_q    <= '0;
      stopped_q <= 1'b0;
      for (int k = 0; k < aae_pkg::NumPar; k++) begin
        par_q[k] <= (k == 0 || k == 2) ? aae_pkg::ParOne : '0;
      end
    end else begin
      if (mul_req.start || div_req.start) issued_q <= 1'b1;
      if (mul_rsp.done || div_rsp.done) issued_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            idx_q <= '0;
            if (in_i.restart) begin
              for (int k = 0; k < aae_pkg::NumPar; k++) begin
                par_q[k] <= (k == 0 || k == 2) ? aae_pkg::ParOne : '0;
              end
              hit_q     <= '0;
              iter_q    <= '0;
              stopped_q <= 1'b0;
            end
            upd_q   <= in_i.restart || !stopped_q;
            state_q <= (in_i.restart || !stopped_q) ? S_PHA : S_SUM;
          end
        end
        S_PHA: if (mul_rsp.done) state_q <= S_PHB;
        S_PHB: begin
          if (mul_rsp.done) begin
            if (idx_q == 3'd5) begin
              idx_q   <= '0;
              state_q <= S_ZH;
            end else begin
              idx_q   <= idx_q + 3'd1;
              state_q <= S_PHA;
            end
          end
        end
        S_ZH: begin
          if (mul_rsp.done) begin
            if (idx_q == 3'd5) begin
              idx_q   <= '0;
              state_q <= S_EST;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        S_EST: state_q <= S_GRD;
        S_GRD: if (mul_rsp.done) state_q <= S_DLT;
        S_DLT: begin
          if (mul_rsp.done) begin
            par_q[idx_q] <= aae_pkg::sat48(par_sum);
            if (idx_q == 3'd5) begin
              state_q <= S_SUM;
            end else begin
              idx_q   <= idx_q + 3'd1;
              state_q <= S_GRD;
            end
          end
        end
        S_SUM: begin
          idx_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if ((sum_q == '0) || div_rsp.done) begin
            if (idx_q == 3'd2) begin
              idx_q   <= '0;
              state_q <= S_TGT;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        S_TGT: begin
          if (mul_rsp.done) begin
            if (idx_q == 3'd2) begin
              idx_q   <= '0;
              state_q <= S_TGS;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        S_TGS: state_q <= S_ERR;
        S_ERR: begin
          if (mul_rsp.done) begin
            if (idx_q == 3'd2) state_q <= S_FIN;
            else idx_q <= idx_q + 3'd1;
          end
        end
        S_FIN: begin
          hit_q     <= hit_n;
          iter_q    <= iter_n;
          stopped_q <= stop_n;
          state_q   <= S_OUT;
        end
        S_OUT: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Working values carry no reset: each pair writes them before use.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      crd_a_q[0] <= in_i.first_x;
      crd_a_q[1] <= in_i.first_y;
      crd_a_q[2] <= in_i.first_z;
      crd_b_q[0] <= in_i.second_x;
      crd_b_q[1] <= in_i.second_y;
      crd_b_q[2] <= in_i.second_z;
      acc_q      <= '0;
    end
    case (state_q)
      S_PHA: if (mul_rsp.done) m1_q <= mul_rsp.prod;
      S_PHB: if (mul_rsp.done) phi_q[idx_q] <= aae_pkg::sat48(phi_diff >>> 16);
      S_ZH:  if (mul_rsp.done) acc_q <= acc_q + mul_rsp.prod;
      S_EST: e_q <= aae_pkg::sat64(zh_neg >>> 16);
      S_GRD: if (mul_rsp.done) g_q <= aae_pkg::sat64(mul_rsp.prod >>> 16);
      S_SUM: sum_q <= {{2{par_q[0][47]}}, par_q[0]} + {{2{par_q[1][47]}}, par_q[1]}
                    + {{2{par_q[2][47]}}, par_q[2]};
      S_DIV: begin
        if (sum_q == '0) begin
          // Zero diagonal sum: the normalised term saturates by its sign.
          if (par_sel == '0) nrm_q[i3] <= '0;
          else nrm_q[i3] <= par_sel[47] ? aae_pkg::Min48 : aae_pkg::Max48;
        end else if (div_rsp.done) begin
          nrm_q[i3] <= div_neg ? -$signed(div_rsp.quot) : $signed(div_rsp.quot);
        end
      end
      S_TGT: if (mul_rsp.done) sq_q[i3] <= mul_rsp.prod[62:0];
      S_TGS: begin
        tgt_q[0] <= 36'(({1'b0, sq_q[1]} + {1'b0, sq_q[2]}) >> 28);
        tgt_q[1] <= 36'(({1'b0, sq_q[0]} + {1'b0, sq_q[2]}) >> 28);
        tgt_q[2] <= 36'(({1'b0, sq_q[0]} + {1'b0, sq_q[1]}) >> 28);
        acc_q    <= '0;
      end
      S_ERR: if (mul_rsp.done) acc_q <= acc_q + mul_rsp.prod;
      S_FIN: begin
        esq_q  <= esq_n;
        conv_q <= hit_n >= hits_need_q;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      for (int k = 0; k < aae_pkg::NumPar; k++) o_est_q[k] <= par_q[k];
      for (int k = 0; k < 3; k++) o_nrm_q[k] <= nrm_q[k];
      o_esq_q  <= esq_q;
      o_conv_q <= conv_q;
      o_done_q <= stopped_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.est_xx    = o_est_q[0];
  assign out_o.est_yy    = o_est_q[1];
  assign out_o.est_zz    = o_est_q[2];
  assign out_o.est_xy    = o_est_q[3];
  assign out_o.est_yz    = o_est_q[4];
  assign out_o.est_xz    = o_est_q[5];
  assign out_o.norm_xx   = o_nrm_q[0];
  assign out_o.norm_yy   = o_nrm_q[1];
  assign out_o.norm_zz   = o_nrm_q[2];
  assign out_o.error_sq  = o_esq_q;
  assign out_o.converged = o_conv_q;
  assign out_o.done_res  = o_done_q;

endmodule

`default_nettype wire

// ===== rtl/aae_checker.sv =====
// ----------------------------------------------------------------------------
// aae_checker: port-level checks for the adaptive axis estimator
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module aae_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [47:0] est_xx_i,
  input wire logic        converged_i,
  input wire logic        done_res_i
);

  // One pair at a time: the input closes after each transfer.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted again while a pair is in work");

  // No result can appear the cycle after a pair is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("result appeared straight after an input transfer");

  // Convergence always stops the estimator.
  a_conv_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && converged_i) |-> done_res_i)
    else $error("converged reported without done");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(est_xx_i)))
    else $error("stalled result dropped or changed");

endmodule

bind adaptive_axis_estimator aae_checker u_aae_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .est_xx_i    (out_o.est_xx),
  .converged_i (out_o.converged),
  .done_res_i  (out_o.done_res)
);

`default_nettype wire

// ===== verif/tb_adaptive_axis_estimator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adaptive_axis_estimator: self-checking bench for the axis estimator
// Drives point pairs with random gaps and writes the registers over the
// configuration port. A bit-true predictor in the bench works out each
// estimate transfer, and a checker compares every output field against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_adaptive_axis_estimator;

  // One point pair as it is offered on the input channel.
  typedef struct packed {
    logic signed [31:0] fx, fy, fz, sx, sy, sz;
    logic               restart;
  } pair_t;

  // One estimate transfer: six parameters, three norms and the error.
  typedef struct packed {
    logic [9:0][47:0] word;
    logic             conv;
    logic             done;
  } estimate_t;

  localparam int CycleLimit = 6000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  aae_in_if #(.COORD_WIDTH(32)) pair_ch ();
  aae_out_if est_ch ();

  adaptive_axis_estimator #(.COORD_WIDTH(32)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(pair_ch.sink), .out_o(est_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk_i = ~clk_i;

  // Bench copy of the block's state and registers.
  logic signed [47:0] par [6];
  int unsigned hits, iters;
  logic halted;
  logic [47:0] gain_q48, thr_sq;
  logic signed [31:0] axis_u, axis_v, axis_w;
  logic [15:0] hits_goal;
  logic [19:0] iter_cap;

  estimate_t expected_estimates[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int zero_sum_seen = 0;
  int halted_seen = 0;
  longint cycles = 0;

  // Receiver control: a hold-off count and a no-stall switch.
  int hold_cycles = 0;
  logic quiet = 1'b0;

  // Saturate a wide signed value to the given width, sign-extended to 64 bits.
  function automatic logic signed [63:0] clip(input logic signed [127:0] x,
                                               input int bits);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    if (x > hi) return hi[63:0];
    if (x < lo) return lo[63:0];
    return x[63:0];
  endfunction

  function automatic void clear_estimate();
    foreach (par[i]) par[i] = '0;
    par[0] = aae_pkg::ParOne;
    par[2] = aae_pkg::ParOne;
    hits = 0;
    iters = 0;
    halted = 1'b0;
  endfunction

  // One projected gradient step on the parameters.
  function automatic void gradient_step(input pair_t p);
    int ii[6] = '{0, 1, 2, 0, 1, 0};
    int jj[6] = '{0, 1, 2, 1, 2, 2};
    logic signed [127:0] a[3], b[3], zh, d, ph, ew, gw, sg, pw;
    logic signed [63:0] phi[6], e, g, dd;
    a[0] = p.fx; a[1] = p.fy; a[2] = p.fz;
    b[0] = p.sx; b[1] = p.sy; b[2] = p.sz;
    zh = '0;
    for (int i = 0; i < 6; i++) begin
      d = a[ii[i]] * a[jj[i]] - b[ii[i]] * b[jj[i]];
      phi[i] = clip(d >>> 16, 48);
      ph = phi[i];
      pw = par[i];
      zh = zh + pw * ph;
    end
    e = clip((-zh) >>> 16, 64);
    ew = e;
    sg = {80'd0, gain_q48};
    for (int i = 0; i < 6; i++) begin
      ph = phi[i];
      g = clip((ph * ew) >>> 16, 64);
      gw = g;
      dd = clip((gw * sg) >>> 48, 64);
      // Projection: a negative diagonal term is not pushed further down.
      if (i < 3 && par[i] < 0 && dd < 0) dd = '0;
      pw = par[i];
      gw = dd;
      par[i] = 48'(clip(pw + gw, 48));
    end
  endfunction

  // Diagonal scaled by 2/sum, Q16.32, truncated toward zero.
  function automatic void scale_diagonal(output logic signed [47:0] nrm[3]);
    logic signed [63:0] sum, pv;
    logic [63:0] mag, dm;
    logic [127:0] q, cap;
    logic neg;
    sum = 64'(par[0]) + 64'(par[1]) + 64'(par[2]);
    for (int i = 0; i < 3; i++) begin
      pv = par[i];
      if (sum == 0) begin
        nrm[i] = pv > 0 ? aae_pkg::Max48 : (pv < 0 ? aae_pkg::Min48 : 48'sd0);
      end else begin
        mag = pv < 0 ? -pv : pv;
        dm = sum < 0 ? -sum : sum;
        neg = pv != 0 && ((pv < 0) != (sum < 0));
        q = ({64'd0, mag} << 33) / {64'd0, dm};
        cap = neg ? (128'd1 << 47) : (128'd1 << 47) - 1;
        if (q > cap) q = cap;
        nrm[i] = neg ? -q[47:0] : q[47:0];
      end
    end
  endfunction

  function automatic logic [47:0] diagonal_error(input logic signed [47:0] nrm[3]);
    logic signed [63:0] u, v, w, e;
    logic [63:0] uu, vv, ww;
    logic signed [63:0] tgt[3];
    logic signed [127:0] acc, ew;
    u = axis_u; v = axis_v; w = axis_w;
    uu = u * u; vv = v * v; ww = w * w;
    tgt[0] = (vv + ww) >> 28;
    tgt[1] = (uu + ww) >> 28;
    tgt[2] = (uu + vv) >> 28;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      e = 64'(nrm[i]) - tgt[i];
      ew = e;
      acc = acc + ew * ew;
    end
    acc = acc >>> 32;
    if (acc > 128'sd281474976710655) return aae_pkg::Mask48;
    return acc[47:0];
  endfunction

  // Advances the bench state by one accepted pair and returns the estimate.
  function automatic estimate_t estimate_after(input pair_t p);
    estimate_t r;
    logic signed [47:0] nrm[3];
    logic [47:0] esq;
    logic signed [63:0] sum;
    if (p.restart) clear_estimate();
    if (!halted) begin
      gradient_step(p);
      scale_diagonal(nrm);
      esq = diagonal_error(nrm);
      if (esq < thr_sq && hits < 65535) hits++;
      iters = (iters + 1) & 20'hFFFFF;
      if (hits >= hits_goal || iters >= iter_cap) halted = 1'b1;
    end else begin
      halted_seen++;
      scale_diagonal(nrm);
      esq = diagonal_error(nrm);
    end
    sum = 64'(par[0]) + 64'(par[1]) + 64'(par[2]);
    if (sum == 0) zero_sum_seen++;
    for (int i = 0; i < 6; i++) r.word[i] = par[i];
    for (int i = 0; i < 3; i++) r.word[6 + i] = nrm[i];
    r.word[9] = esq;
    r.conv = hits >= hits_goal;
    r.done = halted;
    return r;
  endfunction

  // ---- Configuration port ---------------------------------------------------
  // The transfer of one register value: setup cycle, then access cycle.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 3'b000};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      aae_pkg::RegStepGain:  gain_q48 = value[47:0];
      aae_pkg::RegThreshold: thr_sq = value[47:0];
      aae_pkg::RegAxisX:     axis_u = value[31:0];
      aae_pkg::RegAxisY:     axis_v = value[31:0];
      aae_pkg::RegAxisZ:     axis_w = value[31:0];
      aae_pkg::RegHitsNeed:  hits_goal = value[15:0];
      aae_pkg::RegMaxIter:   iter_cap = value[19:0];
      default: ;
    endcase
  endtask

  // Every pair yields one transfer, so an empty queue means the block is idle.
  task automatic drain();
    @(negedge clk_i);
    pair_ch.valid = 1'b0;
    while (expected_estimates.size() != 0) @(posedge clk_i);
  endtask

  // Offers one pair, after a random gap unless quiet is set, and waits for its transfer.
  task automatic send_pair(input pair_t p);
    @(negedge clk_i);
    if (!quiet) begin
      while ($urandom_range(99) < 32) begin
        pair_ch.valid = 1'b0;
        @(negedge clk_i);
      end
    end
    pair_ch.valid = 1'b1;
    pair_ch.first_x = p.fx; pair_ch.first_y = p.fy; pair_ch.first_z = p.fz;
    pair_ch.second_x = p.sx; pair_ch.second_y = p.sy; pair_ch.second_z = p.sz;
    pair_ch.restart = p.restart;
    do @(posedge clk_i); while (!pair_ch.ready);
    expected_estimates.insert(expected_estimates.size(), estimate_after(p));
    sent++;
  endtask

  function automatic pair_t make_pair(input logic signed [31:0] fx, fy, fz, sx, sy, sz,
                                      input logic restart);
    pair_t p;
    p.fx = fx; p.fy = fy; p.fz = fz; p.sx = sx; p.sy = sy; p.sz = sz;
    p.restart = restart;
    return p;
  endfunction

  // A coordinate of moderate size (within about +/-4.0), or any 32-bit value
  // when wild is set.
  function automatic logic signed [31:0] coord(input logic wild);
    if (wild) return $urandom;
    return $signed($urandom_range(524287)) - 32'sd262144;
  endfunction

  function automatic pair_t random_pair(input logic wild, input logic restart);
    return make_pair(coord(wild), coord(wild), coord(wild), coord(wild), coord(wild),
                     coord(wild), restart);
  endfunction

  // ---- Receiver: random stalls plus a counted hold-off ----------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      est_ch.ready = 1'b0;
    end else if (hold_cycles > 0) begin
      est_ch.ready = 1'b0;
      hold_cycles--;
    end else if (quiet) begin
      est_ch.ready = 1'b1;
    end else begin
      est_ch.ready = $urandom_range(99) >= 32;
    end
  end

  task automatic check_field(input string name, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // ---- Checker: every estimate transfer against the oldest expectation ------
  always @(posedge clk_i) begin
    estimate_t got, want;
    if (rst_ni && est_ch.valid && est_ch.ready) begin
      got.word[0] = est_ch.est_xx; got.word[1] = est_ch.est_yy;
      got.word[2] = est_ch.est_zz; got.word[3] = est_ch.est_xy;
      got.word[4] = est_ch.est_yz; got.word[5] = est_ch.est_xz;
      got.word[6] = est_ch.norm_xx; got.word[7] = est_ch.norm_yy;
      got.word[8] = est_ch.norm_zz; got.word[9] = est_ch.error_sq;
      got.conv = est_ch.converged;
      got.done = est_ch.done_res;
      received++;
      if (expected_estimates.size() == 0) begin
        $error("estimate transfer with nothing expected");
        errors++;
      end else begin
        want = expected_estimates.pop_front();
        check_field("est_xx", want.word[0], got.word[0]);
        check_field("est_yy", want.word[1], got.word[1]);
        check_field("est_zz", want.word[2], got.word[2]);
        check_field("est_xy", want.word[3], got.word[3]);
        check_field("est_yz", want.word[4], got.word[4]);
        check_field("est_xz", want.word[5], got.word[5]);
        check_field("norm_xx", want.word[6], got.word[6]);
        check_field("norm_yy", want.word[7], got.word[7]);
        check_field("norm_zz", want.word[8], got.word[8]);
        check_field("error_sq", want.word[9], got.word[9]);
        check_field("converged", 48'(want.conv), 48'(got.conv));
        check_field("done_res", 48'(want.done), 48'(got.done));
      end
    end
  end

  // A watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d estimates outstanding",
               cycles, expected_estimates.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---- Tests ----------------------------------------------------------------
  // Field extremes at reset values, then the zero diagonal sum, the projection and the stops.
  task automatic test_directed();
    logic signed [31:0] mx, mn, two;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    two = 32'sd131072;
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 1'b0));
    send_pair(make_pair(65536, 0, 0, 0, 65536, 0, 1'b0));
    send_pair(make_pair(mx, mx, mx, mn, mn, mn, 1'b0));
    send_pair(make_pair(mn, mn, mn, mx, mx, mx, 1'b0));
    send_pair(make_pair(mx, mn, mx, 0, 0, 0, 1'b1));
    send_pair(make_pair(-1, -1, -1, 1, 1, 1, 1'b1));
    send_pair(make_pair(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                        32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b1));
    drain();
    // With a gain of 2^-3 and a pure x pair of 2.0, xx goes from 1 to -1, so
    // the diagonal sums to zero and the norms saturate.
    write_reg(aae_pkg::RegStepGain, 64'd1 << 45);
    send_pair(make_pair(two, 0, 0, 0, 0, 0, 1'b1));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 1'b0));
    // Second point dominant: the gradient on the negative xx term is tested
    // against the projection.
    send_pair(make_pair(0, 65536, 0, two, 0, 0, 1'b0));
    send_pair(make_pair(65536, 65536, 0, 0, 0, 0, 1'b0));
    drain();
    // Stop by convergence, ignored pairs while stopped, then a restart.
    write_reg(aae_pkg::RegThreshold, aae_pkg::Mask48);
    write_reg(aae_pkg::RegHitsNeed, 64'd1);
    send_pair(make_pair(65536, 0, 0, 0, 0, 0, 1'b1));
    send_pair(make_pair(two, two, two, 0, 0, 0, 1'b0));
    send_pair(make_pair(0, two, 0, 0, 0, 0, 1'b1));
    drain();
    // Zero goals: both stop after the first pair.
    write_reg(aae_pkg::RegHitsNeed, 64'd0);
    send_pair(make_pair(0, 0, 65536, 0, 0, 0, 1'b1));
    send_pair(make_pair(0, 0, 65536, 0, 0, 0, 1'b0));
    drain();
    write_reg(aae_pkg::RegHitsNeed, 64'd65535);
    write_reg(aae_pkg::RegMaxIter, 64'd0);
    send_pair(make_pair(65536, 65536, 0, 0, 0, 0, 1'b1));
    send_pair(make_pair(65536, 65536, 0, 0, 0, 0, 1'b0));
    drain();
  endtask

  // One configuration per phase, extremes included.
  task automatic load_setting(input int k);
    logic [63:0] g, t, x, y, z, h, m;
    case (k % 6)
      0: begin g = 64'(aae_pkg::StepGainRst); t = 64'(aae_pkg::ThresholdRst); x = 0;
               y = 0; z = 32'h4000_0000; h = 100; m = 20000; end
      1: begin g = aae_pkg::Mask48; t = aae_pkg::Mask48; x = 32'h8000_0000;
               y = 32'h7FFF_FFFF; z = 32'h8000_0000; h = 65535; m = 20'hFFFFF; end
      2: begin g = 0; t = 0; x = 32'h7FFF_FFFF; y = 32'h8000_0000;
               z = 32'h7FFF_FFFF; h = 1; m = 1; end
      3: begin g = $urandom_range(1 << 30) << 16; t = {$urandom, 16'h0};
               x = $urandom; y = $urandom; z = $urandom; h = $urandom_range(1, 8);
               m = $urandom_range(5, 60); end
      4: begin g = 64'd1 << 40; t = 64'd1 << 34; x = 32'h2D41_3CCD; y = 0;
               z = 32'h2D41_3CCD; h = $urandom_range(2, 20); m = $urandom_range(10, 80); end
      default: begin g = {$urandom, $urandom} & aae_pkg::Mask48;
               t = {$urandom, $urandom} & aae_pkg::Mask48;
               x = $urandom; y = $urandom; z = $urandom; h = $urandom & 16'hFFFF;
               m = $urandom & 20'hFFFFF; end
    endcase
    write_reg(aae_pkg::RegStepGain, g);
    write_reg(aae_pkg::RegThreshold, t);
    write_reg(aae_pkg::RegAxisX, x);
    write_reg(aae_pkg::RegAxisY, y);
    write_reg(aae_pkg::RegAxisZ, z);
    write_reg(aae_pkg::RegHitsNeed, h);
    write_reg(aae_pkg::RegMaxIter, m);
  endtask

  // Episodes: a restart then a run of moderate pairs; some wild pairs and
  // stray restarts mixed in as noise.
  task automatic test_random_episodes(input int phases, input int per_phase);
    int n, left;
    for (int ph = 0; ph < phases; ph++) begin
      drain();
      load_setting(ph);
      quiet = (ph == 2);
      left = per_phase;
      while (left > 0) begin
        n = $urandom_range(4, 40);
        for (int i = 0; i < n && left > 0; i++) begin
          if ($urandom_range(99) < 12)
            send_pair(random_pair(1'b1, $urandom_range(9) == 0));
          else
            send_pair(random_pair(1'b0, i == 0));
          left--;
        end
      end
    end
    quiet = 1'b0;
  endtask

  // The receiver holds off while pairs keep coming, so the block backs up.
  task automatic test_backpressure();
    drain();
    load_setting(0);
    hold_cycles = 4000;
    for (int i = 0; i < 12; i++) send_pair(random_pair(1'b0, i == 0));
    drain();
  endtask

  initial begin
    pair_ch.valid = 1'b0;
    pair_ch.restart = 1'b0;
    pair_ch.first_x = '0; pair_ch.first_y = '0; pair_ch.first_z = '0;
    pair_ch.second_x = '0; pair_ch.second_y = '0; pair_ch.second_z = '0;
    est_ch.ready = 1'b0;
    gain_q48 = aae_pkg::StepGainRst; thr_sq = aae_pkg::ThresholdRst;
    axis_u = aae_pkg::AxisXRst; axis_v = aae_pkg::AxisYRst; axis_w = aae_pkg::AxisZRst;
    hits_goal = aae_pkg::HitsNeedRst; iter_cap = aae_pkg::MaxIterRst;
    clear_estimate();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_backpressure();
    test_random_episodes(10, 172);

    drain();
    repeat (600) @(posedge clk_i);
    $display("Covered %0d pairs and %0d estimates over ten register settings,", sent,
             received);
    $display("with %0d zero diagonal sums and %0d pairs met while stopped.",
             zero_sum_seen, halted_seen);
    if (errors == 0 && expected_estimates.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
